// File: sv/cdgm_pkg.sv
// ----------------------------------------------------------------------------
// cdgm_pkg
// Shared types, constants and arithmetic helpers of the gradient magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdgm_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;

    // line store banks
    localparam int NUM_BANKS = 3;
    localparam int BANK_W    = 2;

    // result kinds a single pixel can cause
    localparam int JOB_KINDS = 4;

    // square root datapath
    localparam int ENERGY_W    = 17;
    localparam int REM_W       = 16;
    localparam int ROOT_STEPS  = 4;
    localparam int ROOT_HI_TOP = 14;
    localparam int ROOT_LO_TOP = 6;

    // gray = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;
    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } front_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] down;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             run_last;
        logic             frame_done;
    } job_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] acc;
    } root_t;

    function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;
        sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
        prod = PROD_W'(sum) * PROD_W'(GRAY_RECIP);
        return prod[GRAY_SHIFT +: PIX_W];
    endfunction

    // four digits of the bitwise floor square root, upper or lower half
    function automatic root_t root_steps(input logic [REM_W-1:0] rem,
                                         input logic [REM_W-1:0] acc,
                                         input logic             lo_half);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] a;
        logic [REM_W-1:0] b;
        logic [REM_W-1:0] t;
        int               sh;
        root_t            o;
        r = rem;
        a = acc;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            sh = lo_half ? (ROOT_LO_TOP - 2 * k) : (ROOT_HI_TOP - 2 * k);
            b  = REM_W'(1) << sh;
            t  = a + b;
            if (r >= t) begin
                r = r - t;
                a = (a >> 1) + b;
            end else begin
                a = a >> 1;
            end
        end
        o.rem = r;
        o.acc = a;
        return o;
    endfunction

endpackage

// File: sv/cdgm_fifo.sv
// ----------------------------------------------------------------------------
// cdgm_fifo
// Short job queue between the pixel front end and the magnitude back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdgm_fifo #(
    parameter int DEPTH = cdgm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cdgm_pkg::job_t  din,
    output logic            full,
    input  logic            pop,
    output cdgm_pkg::job_t  dout,
    output logic            empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cdgm_pkg::job_t  store [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= din;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job popped from an empty queue");

    a_fill_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == CNTW'($past(count_reg) + CNTW'(1))))
        else $error("queue fill level lost a pushed job");
`endif

endmodule

// File: sv/cdgm_front.sv
// ----------------------------------------------------------------------------
// cdgm_front
// Takes pixels, keeps the gray line stores and classifies each pixel into jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdgm_front #(
    parameter int MAX_WIDTH  = cdgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cdgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [23:0]     s_axis_tdata,
    input  cdgm_pkg::cfg_t  cfg,
    input  logic            job_ready,
    output logic            job_push,
    output cdgm_pkg::job_t  job
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WEW = CW + 1;
    localparam int HEW = RW + 1;
    localparam int PW  = cdgm_pkg::PIX_W;
    localparam int BW  = cdgm_pkg::BANK_W;
    localparam int JK  = cdgm_pkg::JOB_KINDS;

    // job kinds, in emission order
    localparam int JOB_UPPER_LAG = 0;
    localparam int JOB_UPPER_END = 1;
    localparam int JOB_LAST_LAG  = 2;
    localparam int JOB_LAST_END  = 3;

    cdgm_pkg::front_state_t state_reg, state_next;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [BW-1:0] cur_reg, cur_next;
    logic [JK-1:0] mask_reg, mask_next;
    logic [PW-1:0] g0_reg, g0_next;
    logic [PW-1:0] g1_reg, g1_next;
    logic [PW-1:0] g2_reg, g2_next;
    logic [PW-1:0] p1_reg, p1_next;
    logic [PW-1:0] p2_reg, p2_next;
    logic [PW-1:0] u1_reg, u1_next;

    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;
    logic           row_end;
    logic           last_row;
    logic [BW-1:0]  prev_sel;
    logic [BW-1:0]  old_sel;
    logic [PW-1:0]  gray;
    logic           accept;
    logic           job_valid;
    logic [JK-1:0]  pick;
    logic [PW-1:0]  rp;
    logic [PW-1:0]  ro;
    logic [PW-1:0]  uc;
    logic [CW-1:0]  col_lag;
    logic [RW-1:0]  row_prev;

    logic [cdgm_pkg::NUM_BANKS-1:0][PW-1:0] bank_rd;

    // effective frame size, zero counts as one, anything past the maximum as the maximum
    always_comb begin
        if (cfg.width == '0) begin
            w_eff = WEW'(1);
        end else if (cfg.width > MAX_WIDTH) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(cfg.width);
        end
        if (cfg.height == '0) begin
            h_eff = HEW'(1);
        end else if (cfg.height > MAX_HEIGHT) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = HEW'(cfg.height);
        end
    end

    assign row_end  = ((WEW'(col_reg) + WEW'(1)) == w_eff);
    assign last_row = ((HEW'(row_reg) + HEW'(1)) == h_eff);
    assign prev_sel = (cur_reg == '0) ? BW'(cdgm_pkg::NUM_BANKS - 1) : cur_reg - BW'(1);
    assign old_sel  = (cur_reg == BW'(cdgm_pkg::NUM_BANKS - 1)) ? '0 : cur_reg + BW'(1);
    assign gray     = cdgm_pkg::gray_of(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                        s_axis_tdata[23:16]);
    assign s_axis_tready = (state_reg == cdgm_pkg::F_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign rp       = bank_rd[prev_sel];
    assign ro       = bank_rd[old_sel];
    // row above row r-1 is row r-1 itself when r-1 is the top row
    assign uc       = (row_reg == RW'(1)) ? rp : ro;
    assign col_lag  = col_reg - CW'(1);
    assign row_prev = row_reg - RW'(1);
    assign pick     = mask_reg & (~mask_reg + JK'(1));
    assign job_push = job_valid && job_ready;

    // rotating line stores: current row is written, previous and older are read
    for (genvar b = 0; b < cdgm_pkg::NUM_BANKS; b++) begin : g_bank
        logic [PW-1:0] mem [MAX_WIDTH];
        logic [PW-1:0] rd_q;
        always_ff @(posedge aclk) begin
            if (accept) begin
                if (cur_reg == BW'(b)) begin
                    mem[col_reg] <= gray;
                end
                rd_q <= mem[col_reg];
            end
        end
        assign bank_rd[b] = rd_q;
    end

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        mask_next  = mask_reg;
        g0_next    = g0_reg;
        g1_next    = g1_reg;
        g2_next    = g2_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        u1_next    = u1_reg;
        job_valid  = 1'b0;
        unique case (state_reg)
            cdgm_pkg::F_IDLE: begin
                if (s_axis_tvalid) begin
                    mask_next[JOB_UPPER_LAG] = (row_reg != '0) && (col_reg != '0);
                    mask_next[JOB_UPPER_END] = (row_reg != '0) && row_end;
                    mask_next[JOB_LAST_LAG]  = last_row && (col_reg != '0);
                    mask_next[JOB_LAST_END]  = last_row && row_end;
                    g0_next    = gray;
                    state_next = cdgm_pkg::F_EMIT;
                end
            end
            cdgm_pkg::F_EMIT: begin
                job_valid = (mask_reg != '0);
                if (!job_valid || job_ready) begin
                    mask_next = mask_reg & ~pick;
                    if (mask_next == '0) begin
                        // slide the neighbor window and advance the raster position
                        p2_next    = p1_reg;
                        p1_next    = rp;
                        u1_next    = uc;
                        g2_next    = g1_reg;
                        g1_next    = g0_reg;
                        state_next = cdgm_pkg::F_IDLE;
                        if (row_end) begin
                            col_next = '0;
                            row_next = last_row ? '0 : row_reg + RW'(1);
                            cur_next = old_sel;
                        end else begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = cdgm_pkg::F_IDLE;
            end
        endcase
        if (cfg.restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    // operands of the job picked this cycle
    always_comb begin
        job.run_last   = ((mask_reg & ~pick) == '0);
        job.frame_done = 1'b0;
        priority if (pick[JOB_UPPER_LAG]) begin
            job.left   = (col_reg > CW'(1)) ? p2_reg : p1_reg;
            job.right  = rp;
            job.up     = u1_reg;
            job.down   = g1_reg;
            job.column = cdgm_pkg::COL_W'(col_lag);
            job.row    = cdgm_pkg::ROW_W'(row_prev);
        end else if (pick[JOB_UPPER_END]) begin
            job.left   = (col_reg != '0) ? p1_reg : rp;
            job.right  = rp;
            job.up     = uc;
            job.down   = g0_reg;
            job.column = cdgm_pkg::COL_W'(col_reg);
            job.row    = cdgm_pkg::ROW_W'(row_prev);
        end else if (pick[JOB_LAST_LAG]) begin
            job.left   = (col_reg > CW'(1)) ? g2_reg : g1_reg;
            job.right  = g0_reg;
            job.up     = (row_reg == '0) ? g1_reg : p1_reg;
            job.down   = g1_reg;
            job.column = cdgm_pkg::COL_W'(col_lag);
            job.row    = cdgm_pkg::ROW_W'(row_reg);
        end else begin
            job.left       = (col_reg != '0) ? g1_reg : g0_reg;
            job.right      = g0_reg;
            job.up         = (row_reg == '0) ? g0_reg : rp;
            job.down       = g0_reg;
            job.column     = cdgm_pkg::COL_W'(col_reg);
            job.row        = cdgm_pkg::ROW_W'(row_reg);
            job.frame_done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdgm_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            cur_reg   <= '0;
            mask_reg  <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cur_reg   <= cur_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        g0_reg <= g0_next;
        g1_reg <= g1_next;
        g2_reg <= g2_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        u1_reg <= u1_next;
    end

endmodule

// File: sv/cdgm_back.sv
// ----------------------------------------------------------------------------
// cdgm_back
// Gradient energy, split floor square root and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdgm_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_avail,
    input  cdgm_pkg::job_t  job,
    output logic            job_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [31:0]     m_axis_tdata,
    output logic            m_axis_tlast,
    output logic [0:0]      m_axis_tuser
);

    localparam int EW = cdgm_pkg::ENERGY_W;
    localparam int RM = cdgm_pkg::REM_W;
    localparam int PW = cdgm_pkg::PIX_W;
    localparam int CL = cdgm_pkg::COL_W;
    localparam int RL = cdgm_pkg::ROW_W;

    logic signed [PW:0]     dh;
    logic signed [PW:0]     dv;
    logic signed [2*PW+1:0] hh;
    logic signed [2*PW+1:0] vv;
    logic [EW-1:0]          energy;
    cdgm_pkg::root_t        half;
    cdgm_pkg::root_t        whole;
    logic                   out_adv;
    logic                   s2_adv;
    logic                   s1_adv;

    // energy stage
    logic          s1_valid_reg;
    logic [EW-1:0] s1_energy_reg;
    logic [CL-1:0] s1_col_reg;
    logic [RL-1:0] s1_row_reg;
    logic          s1_last_reg;
    logic          s1_done_reg;

    // upper root digits stage
    logic          s2_valid_reg;
    logic [RM-1:0] s2_rem_reg;
    logic [RM-1:0] s2_acc_reg;
    logic          s2_sat_reg;
    logic [CL-1:0] s2_col_reg;
    logic [RL-1:0] s2_row_reg;
    logic          s2_last_reg;
    logic          s2_done_reg;

    // output register
    logic          m_valid_reg;
    logic [PW-1:0] m_mag_reg;
    logic [CL-1:0] m_col_reg;
    logic [RL-1:0] m_row_reg;
    logic          m_last_reg;
    logic          m_done_reg;

    assign out_adv = !m_valid_reg || m_axis_tready;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign job_pop = job_avail && s1_adv;

    assign dh     = $signed({1'b0, job.left}) - $signed({1'b0, job.right});
    assign dv     = $signed({1'b0, job.up}) - $signed({1'b0, job.down});
    assign hh     = dh * dh;
    assign vv     = dv * dv;
    assign energy = {1'b0, hh[RM-1:0]} + {1'b0, vv[RM-1:0]};

    assign half  = cdgm_pkg::root_steps(s1_energy_reg[RM-1:0], '0, 1'b0);
    assign whole = cdgm_pkg::root_steps(s2_rem_reg, s2_acc_reg, 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= job_pop;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            s1_energy_reg <= energy;
            s1_col_reg    <= job.column;
            s1_row_reg    <= job.row;
            s1_last_reg   <= job.run_last;
            s1_done_reg   <= job.frame_done;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_rem_reg  <= half.rem;
            s2_acc_reg  <= half.acc;
            // root of 65536 or more saturates
            s2_sat_reg  <= s1_energy_reg[EW-1];
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;
            s2_done_reg <= s1_done_reg;
        end
        if (out_adv && s2_valid_reg) begin
            m_mag_reg  <= s2_sat_reg ? {PW{1'b1}} : whole.acc[PW-1:0];
            m_col_reg  <= s2_col_reg;
            m_row_reg  <= s2_row_reg;
            m_last_reg <= s2_last_reg;
            m_done_reg <= s2_done_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_row_reg, m_col_reg, m_mag_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_done_reg;

endmodule

// File: sv/central_difference_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// central_difference_gradient_magnitude
// results trail the input by one row and column, on the last row by one column only
// throughput: the front end loop (line store read, then one queue push a cycle while the queue
//   is not full) sets it; a new pixel is taken only after the last result of the one before
// back end runs one result per cycle unless m_axis_tready holds off the output register
// reset: synchronous active low aresetn clears the queue, stages and raster position;
//   line stores are not cleared and need no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module central_difference_gradient_magnitude #(
    parameter int MAX_WIDTH   = cdgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = cdgm_pkg::MAX_HEIGHT_DEF,
    parameter int QUEUE_DEPTH = cdgm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // pixel input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,   // red, green, blue
    // gradient result
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // magnitude, column, row
    output logic                           m_axis_tlast,   // run_last
    output logic [0:0]                     m_axis_tuser,   // frame_done
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [cdgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdgm_pkg::CFG_W-1:0]     cfg_wdata
);

    // frame size registers, any write restarts the frame
    logic [cdgm_pkg::CFG_W-1:0] width_reg, width_next;
    logic [cdgm_pkg::CFG_W-1:0] height_reg, height_next;
    cdgm_pkg::cfg_t             cfg;

    // front end to queue
    logic           q_push;
    logic           q_full;
    cdgm_pkg::job_t q_din;

    // queue to back end
    logic           q_pop;
    logic           q_empty;
    cdgm_pkg::job_t q_dout;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                cdgm_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                cdgm_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cdgm_pkg::DIM_RESET;
            height_reg <= cdgm_pkg::DIM_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;
    assign cfg.restart = cfg_wr_en;

    // front end: gray conversion, line stores, job classification
    cdgm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg),
        .job_ready     (!q_full),
        .job_push      (q_push),
        .job           (q_din)
    );

    // decoupling queue, one entry per result
    cdgm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    // back end: energy, square root, output register
    cdgm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_avail     (!q_empty),
        .job           (q_dout),
        .job_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: tb/sv/tb_central_difference_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// tb_central_difference_gradient_magnitude
// Self-checking bench for the streamed RGB gradient magnitude block. A short
// table of directed pixels and register writes comes first, then random frames
// of many shapes, then a single-row stretch where the receiver holds off while
// pixels keep coming. Every result transaction is compared field by field
// against typed table results or an in-bench model of the gray line stores,
// the clamped central differences and the saturated square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_central_difference_gradient_magnitude;

    // bench sizing
    localparam int          LINE_DEPTH     = 1024;
    localparam int          RANDOM_ITEMS   = 192;
    localparam int          PRESSURE_ITEMS = 64;
    localparam int          SETTLE         = 16;      // cycles past the last result
    localparam int          HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT    = 4_000_000;

    // which line store a neighbour comes from
    typedef enum logic [1:0] {
        LINE_OLDER,
        LINE_PREV,
        LINE_CUR
    } line_sel_t;

    // one gradient result transaction
    typedef struct packed {
        logic [cdgm_pkg::PIX_W-1:0] magnitude;
        logic [cdgm_pkg::COL_W-1:0] column;
        logic [cdgm_pkg::ROW_W-1:0] row;
        logic                       run_last;
        logic                       frame_done;
    } gradient_t;

    // one row of the directed table
    typedef struct {
        bit                             is_cfg;
        logic [cdgm_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [cdgm_pkg::CFG_W-1:0]     reg_value;
        logic [23:0]                    pixel;
        bit                             typed;
        int                             n_typed;
        gradient_t                      typed_res [4];
    } step_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #6 aclk = ~aclk;

    // block ports, the driven ones known from time zero
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata  = '0;   // red, green, blue
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;         // magnitude, column, row
    logic                           m_axis_tlast;         // run_last
    logic [0:0]                     m_axis_tuser;         // frame_done
    logic                           cfg_wr_en     = 1'b0;
    logic [cdgm_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [cdgm_pkg::CFG_W-1:0]     cfg_wdata     = '0;

    central_difference_gradient_magnitude uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // gradient model state: three gray line stores and the raster position
    logic [cdgm_pkg::PIX_W-1:0] older_gray [0:LINE_DEPTH-1];
    logic [cdgm_pkg::PIX_W-1:0] prev_gray  [0:LINE_DEPTH-1];
    logic [cdgm_pkg::PIX_W-1:0] cur_gray   [0:LINE_DEPTH-1];
    int unsigned                col_pos    = 0;
    int unsigned                row_pos    = 0;
    logic [cdgm_pkg::CFG_W-1:0] width_reg  = cdgm_pkg::DIM_RESET;
    logic [cdgm_pkg::CFG_W-1:0] height_reg = cdgm_pkg::DIM_RESET;

    gradient_t   pixel_results [$];     // results of the pixel just modeled
    gradient_t   expected_gradients [$];
    step_t       directed [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          steady_in   = 1'b0;    // sender offers back to back
    bit          hold_armed  = 1'b0;    // receiver holds off once when set

    // ------------------------------------------------------------------------
    // gradient model
    // ------------------------------------------------------------------------

    // zero reads as one, anything past the store depth as the maximum
    function automatic int unsigned clamp_dim(logic [cdgm_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > LINE_DEPTH) return LINE_DEPTH;
        return v;
    endfunction

    function automatic int gray_at(line_sel_t sel, int unsigned x);
        case (sel)
            LINE_OLDER: return older_gray[x];
            LINE_PREV:  return prev_gray[x];
            default:    return cur_gray[x];
        endcase
    endfunction

    // clamped central differences, then floor sqrt saturated to a byte
    function automatic gradient_t gradient_at(line_sel_t up_sel, line_sel_t mid_sel,
                                              line_sel_t dn_sel, int unsigned x,
                                              int unsigned w, int unsigned y, bit done);
        int unsigned lx;
        int unsigned rx;
        int          hd;
        int          vd;
        int          energy;
        int          root;
        int          trial;
        gradient_t   g;
        lx     = (x >= 1) ? x - 1 : x;
        rx     = (x + 1 < w) ? x + 1 : x;
        hd     = gray_at(mid_sel, lx) - gray_at(mid_sel, rx);
        vd     = gray_at(up_sel, x) - gray_at(dn_sel, x);
        energy = hd * hd + vd * vd;
        root   = 0;
        // energy stays below 2**18, so nine root bits suffice
        for (int b = 8; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= energy) root = trial;
        end
        g.magnitude  = (root > 255) ? 8'd255 : cdgm_pkg::PIX_W'(root);
        g.column     = cdgm_pkg::COL_W'(x);
        g.row        = cdgm_pkg::ROW_W'(y);
        g.run_last   = 1'b0;
        g.frame_done = done;
        return g;
    endfunction

    // advance the model by one pixel, leaving its results in pixel_results
    task automatic predict_gradients(input logic [23:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          row_end;
        bit          last_row;
        line_sel_t   up_sel;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        row_end  = (c + 1 == w);
        last_row = (r + 1 == h);
        cur_gray[c] = cdgm_pkg::PIX_W'((int'(px[7:0]) + int'(px[15:8])
                                       + int'(px[23:16])) / 3);
        pixel_results.delete();
        // the row above is now complete below, so it can be finished
        if (r >= 1) begin
            up_sel = (r == 1) ? LINE_PREV : LINE_OLDER;
            if (c >= 1)
                pixel_results.push_back(gradient_at(up_sel, LINE_PREV, LINE_CUR,
                                                    c - 1, w, r - 1, 1'b0));
            if (row_end)
                pixel_results.push_back(gradient_at(up_sel, LINE_PREV, LINE_CUR,
                                                    w - 1, w, r - 1, 1'b0));
        end
        // bottom row is flushed as it arrives, down clamps to itself
        if (last_row) begin
            up_sel = (r == 0) ? LINE_CUR : LINE_PREV;
            if (c >= 1)
                pixel_results.push_back(gradient_at(up_sel, LINE_CUR, LINE_CUR,
                                                    c - 1, w, r, 1'b0));
            if (row_end)
                pixel_results.push_back(gradient_at(up_sel, LINE_CUR, LINE_CUR,
                                                    w - 1, w, r, 1'b1));
        end
        if (pixel_results.size() > 0)
            pixel_results[pixel_results.size() - 1].run_last = 1'b1;
        if (row_end) begin
            older_gray = prev_gray;
            prev_gray  = cur_gray;
            col_pos    = 0;
            row_pos    = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // ------------------------------------------------------------------------
    // directed table building
    // ------------------------------------------------------------------------

    task automatic add_cfg(input logic [cdgm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cdgm_pkg::CFG_W-1:0] val);
        step_t st;
        st.is_cfg    = 1'b1;
        st.reg_idx   = idx;
        st.reg_value = val;
        st.pixel     = '0;
        st.typed     = 1'b0;
        st.n_typed   = 0;
        directed.push_back(st);
    endtask

    // typed rows are checked against the results attached with add_typed
    task automatic add_pixel(input logic [23:0] px, input bit typed);
        step_t st;
        st.is_cfg    = 1'b0;
        st.reg_idx   = '0;
        st.reg_value = '0;
        st.pixel     = px;
        st.typed     = typed;
        st.n_typed   = 0;
        directed.push_back(st);
    endtask

    task automatic add_typed(input int mag, input int col, input int row,
                             input bit last, input bit done);
        int k;
        k = directed.size() - 1;
        directed[k].typed_res[directed[k].n_typed] =
            '{cdgm_pkg::PIX_W'(mag), cdgm_pkg::COL_W'(col), cdgm_pkg::ROW_W'(row),
              last, done};
        directed[k].n_typed++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 0;
        if (pick < 8) return $urandom_range(1, 3);
        if (pick < 9) return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    function automatic int receiver_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) return $urandom_range(1, 3);
        if (pick < 18) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // full random, faint values for small gradients, or saturated channels
    function automatic logic [23:0] random_pixel(int style);
        int s;
        s = (style == 3) ? $urandom_range(0, 2) : style;
        case (s)
            0:       return 24'($urandom);
            1:       return {4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom)};
            default: return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
        endcase
    endfunction

    // let every outstanding result drain before touching the registers
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_gradients.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // each write restarts the frame on both sides
    task automatic write_register(input logic [cdgm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cdgm_pkg::CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == cdgm_pkg::REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    // offer one pixel, model it on acceptance, then maybe idle
    task automatic send_pixel(input logic [23:0] px, input int typed_row);
        int gap;
        s_axis_tdata  <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_gradients(px);
        if (typed_row >= 0) begin
            for (int k = 0; k < directed[typed_row].n_typed; k++)
                expected_gradients.push_back(directed[typed_row].typed_res[k]);
        end else begin
            foreach (pixel_results[k]) expected_gradients.push_back(pixel_results[k]);
        end
        gap = steady_in ? 0 : sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // bursts of ready, short and long stalls, no-stall stretches, one long hold
    initial begin : result_drive
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_armed) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_armed = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(20, 80);
                repeat (n) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge aclk);
                m_axis_tready <= 1'b0;
                n = receiver_gap();
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] expv,
                                 input logic [31:0] actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            error_count++;
        end
    endtask

    // every result transaction against the oldest expectation
    always @(posedge aclk) begin : result_check
        gradient_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_gradients.size() == 0) begin
                $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_gradients.pop_front();
                compare_field("magnitude", 32'(want.magnitude), 32'(m_axis_tdata[7:0]));
                compare_field("column", 32'(want.column), 32'(m_axis_tdata[17:8]));
                compare_field("row", 32'(want.row), 32'(m_axis_tdata[27:18]));
                compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[31:28]));
                compare_field("run_last", 32'(want.run_last), 32'(m_axis_tlast));
                compare_field("frame_done", 32'(want.frame_done), 32'(m_axis_tuser[0]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int          random_items;
        int          npix;
        int          style;
        logic [10:0] w_val;
        logic [10:0] h_val;
        int unsigned frame_px;

        // model stores start cleared, the block's are never read before written
        foreach (older_gray[i]) begin
            older_gray[i] = '0;
            prev_gray[i]  = '0;
            cur_gray[i]   = '0;
        end

        // reset defaults: first pixels of a 1024 x 1024 frame give nothing yet
        add_pixel(24'h0000ff, 1'b1);
        add_pixel(24'h00ff00, 1'b1);
        // zero dimensions read as a 1 x 1 frame: every pixel is its own frame
        add_cfg(cdgm_pkg::REG_IMAGE_WIDTH, 11'd0);
        add_cfg(cdgm_pkg::REG_IMAGE_HEIGHT, 11'd0);
        add_pixel(24'hffffff, 1'b1);
        add_typed(0, 0, 0, 1'b1, 1'b1);
        add_pixel(24'h000000, 1'b1);
        add_typed(0, 0, 0, 1'b1, 1'b1);
        // 2 x 2 diagonal pattern: all four results come on the last pixel, saturated
        add_cfg(cdgm_pkg::REG_IMAGE_WIDTH, 11'd2);
        add_cfg(cdgm_pkg::REG_IMAGE_HEIGHT, 11'd2);
        add_pixel(24'hffffff, 1'b1);
        add_pixel(24'h000000, 1'b1);
        add_pixel(24'h000000, 1'b1);
        add_pixel(24'hffffff, 1'b1);
        add_typed(255, 0, 0, 1'b0, 1'b0);
        add_typed(255, 1, 0, 1'b0, 1'b0);
        add_typed(255, 0, 1, 1'b0, 1'b0);
        add_typed(255, 1, 1, 1'b1, 1'b1);
        // second 2 x 2 frame with mixed colors
        add_pixel(24'h1e140a, 1'b0);
        add_pixel(24'h3264c8, 1'b0);
        add_pixel(24'h070000, 1'b0);
        add_pixel(24'h03ff5a, 1'b0);
        // 3 x 3 frame exercising interior and every clamped border
        add_cfg(cdgm_pkg::REG_IMAGE_WIDTH, 11'd3);
        add_cfg(cdgm_pkg::REG_IMAGE_HEIGHT, 11'd3);
        add_pixel(24'h000000, 1'b0);
        add_pixel(24'hffffff, 1'b0);
        add_pixel(24'h7f7f7f, 1'b0);
        add_pixel(24'h030201, 1'b0);
        add_pixel(24'hfefefe, 1'b0);
        add_pixel(24'h204080, 1'b0);
        add_pixel(24'hffffff, 1'b0);
        add_pixel(24'h000000, 1'b0);
        add_pixel(24'h0c0b0a, 1'b0);
        // oversize width reads as the maximum, single row flushes at once
        add_cfg(cdgm_pkg::REG_IMAGE_WIDTH, 11'd2047);
        add_cfg(cdgm_pkg::REG_IMAGE_HEIGHT, 11'd1);
        add_pixel(24'hff00ff, 1'b0);
        add_pixel(24'h00ff00, 1'b0);
        add_pixel(24'h563412, 1'b0);

        // hold reset, then release on an edge
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table; the first writes land mid-frame after the first pixels
        foreach (directed[i]) begin
            if (directed[i].is_cfg) write_register(directed[i].reg_idx, directed[i].reg_value);
            else send_pixel(directed[i].pixel, directed[i].typed ? i : -1);
        end

        // random phases: mostly whole frames, some trailing partial frames
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_val = 11'd0;
                1:       w_val = 11'($urandom_range(1025, 2047));
                2:       w_val = 11'd1;
                default: w_val = 11'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       h_val = 11'd0;
                1:       h_val = 11'($urandom_range(1025, 2047));
                default: h_val = 11'($urandom_range(1, 5));
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(cdgm_pkg::REG_IMAGE_WIDTH, w_val);
                write_register(cdgm_pkg::REG_IMAGE_HEIGHT, h_val);
            end else begin
                write_register(cdgm_pkg::REG_IMAGE_HEIGHT, h_val);
                write_register(cdgm_pkg::REG_IMAGE_WIDTH, w_val);
            end
            frame_px = clamp_dim(w_val) * clamp_dim(h_val);
            // huge frames only get a partial stretch, small ones 1..3 whole frames, now and then plus a partial one
            if (frame_px > 64) begin
                npix = $urandom_range(4, 40);
            end else begin
                npix = frame_px * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) npix += $urandom_range(1, frame_px);
            end
            if (npix > RANDOM_ITEMS - random_items) npix = RANDOM_ITEMS - random_items;
            style     = $urandom_range(0, 3);
            steady_in = ($urandom_range(0, 4) == 0);
            repeat (npix) send_pixel(random_pixel(style), -1);
            steady_in    = 1'b0;
            random_items += npix;
        end

        // one long row offered back to back while the receiver holds off
        write_register(cdgm_pkg::REG_IMAGE_WIDTH, 11'd64);
        write_register(cdgm_pkg::REG_IMAGE_HEIGHT, 11'd1);
        steady_in  = 1'b1;
        hold_armed = 1'b1;
        repeat (PRESSURE_ITEMS) send_pixel(random_pixel(3), -1);
        steady_in = 1'b0;

        // drain and give stray results time to show
        s_axis_tvalid <= 1'b0;
        while (expected_gradients.size() > 0) @(posedge aclk);
        repeat (4 * SETTLE) @(posedge aclk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/cdgm_pkg.sv
sv/cdgm_fifo.sv
sv/cdgm_front.sv
sv/cdgm_back.sv
sv/central_difference_gradient_magnitude.sv
tb/sv/tb_central_difference_gradient_magnitude.sv
